/* sv/first_fit_heap_allocator_defines.svh */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Assert a property on aclk, disabled while reset is asserted.
`define FFHA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Assert a property on aclk that must also hold during reset.
`define FFHA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* sv/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int HEAP_BYTES = 65536;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int LNK_W      = IDX_W + 1;
    localparam int SIZE_W     = 16;
    localparam int HDR_W      = 7;
    localparam int LIM_W      = 17;
    localparam int CFG_IDX_W  = 1;

    localparam logic [LNK_W-1:0] NIL = LNK_W'(MAX_BLOCKS);

    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT   = 1'b1;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FAIL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // One table entry, stored as a single memory word.
    typedef struct packed {
        logic [SIZE_W-1:0] offset;
        logic [SIZE_W-1:0] size;
        logic              is_free;
        logic [LNK_W-1:0]  next;
        logic [LNK_W-1:0]  prev;
    } blk_t;

    localparam int BLK_W = $bits(blk_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_SPLIT_NEXT,
        S_REL_NEXT,
        S_REL_NEXT2,
        S_REL_PREV,
        S_REL_PREV2,
        S_REL_UNLINK,
        S_REL_UNLINK2,
        S_RESP
    } state_t;

    // Free-slot finder status handed to the controller.
    typedef struct packed {
        logic             full;
        logic [IDX_W-1:0] idx;
    } slot_t;

    localparam logic [LIM_W-1:0] LIMIT_CAP =
        LIM_W'((HEAP_BYTES < 65536) ? HEAP_BYTES : 65536);

endpackage

/* sv/ffha_ram.sv */
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/ffha_slots.sv */
// ----------------------------------------------------------------------------
// ffha_slots
// Slot occupancy bits with a lowest-free-slot finder.
// ----------------------------------------------------------------------------
module ffha_slots (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         take,
    input  logic [ffha_pkg::IDX_W-1:0]   take_idx,
    input  logic                         give,
    input  logic [ffha_pkg::IDX_W-1:0]   give_idx,
    output ffha_pkg::slot_t              slot
);

    logic [ffha_pkg::MAX_BLOCKS-1:0] used_reg;
    logic [ffha_pkg::MAX_BLOCKS-1:0] used_next;

    always_comb begin
        used_next = used_reg;
        if (give) begin
            used_next[give_idx] = 1'b0;
        end
        if (take) begin
            used_next[take_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else begin
            used_reg <= used_next;
        end
    end

    // Priority pick of the lowest free slot.
    always_comb begin
        slot.full = 1'b1;
        slot.idx  = '0;
        for (int i = ffha_pkg::MAX_BLOCKS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                slot.full = 1'b0;
                slot.idx  = ffha_pkg::IDX_W'(i);
            end
        end
    end

endmodule

/* sv/ffha_ctrl.sv */
// ----------------------------------------------------------------------------
// ffha_ctrl
// List walker and read-modify-write sequencer over the block table.
// ----------------------------------------------------------------------------
module ffha_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic                          cmd,
    input  logic [ffha_pkg::SIZE_W-1:0]   req_size,
    input  logic [ffha_pkg::SIZE_W-1:0]   addr,
    input  logic [ffha_pkg::HDR_W-1:0]    hdr,
    input  logic [ffha_pkg::LIM_W-1:0]    limit,
    input  logic                          resp_taken,
    output logic                          busy,
    output logic                          resp_valid,
    output logic [ffha_pkg::SIZE_W-1:0]   resp_addr,
    output logic [1:0]                    resp_status,
    // table memory
    output logic                          mem_we,
    output logic [ffha_pkg::IDX_W-1:0]    mem_waddr,
    output ffha_pkg::blk_t                mem_wdata,
    output logic [ffha_pkg::IDX_W-1:0]    mem_raddr,
    input  ffha_pkg::blk_t                mem_rdata,
    // slots
    input  ffha_pkg::slot_t               slot,
    output logic                          slot_take,
    output logic [ffha_pkg::IDX_W-1:0]    slot_take_idx,
    output logic                          slot_give,
    output logic [ffha_pkg::IDX_W-1:0]    slot_give_idx
);

    localparam int IW = ffha_pkg::IDX_W;
    localparam int LW = ffha_pkg::LNK_W;
    localparam int SW = ffha_pkg::SIZE_W;
    localparam int CW = $clog2(ffha_pkg::MAX_BLOCKS + 1);

    ffha_pkg::state_t state_reg, state_next;

    logic [LW-1:0]  head_reg, head_next;
    logic [LW-1:0]  tail_reg, tail_next;
    logic [16:0]    brk_reg, brk_next;
    logic           cmd_reg, cmd_next;
    logic [SW-1:0]  size_reg, size_next;
    logic [SW-1:0]  addr_reg, addr_next;
    logic [LW-1:0]  cur_reg, cur_next;
    logic [CW-1:0]  steps_reg, steps_next;
    ffha_pkg::blk_t blk_reg, blk_next;     // copy of current entry
    ffha_pkg::blk_t oth_reg, oth_next;     // copy of a neighbour entry
    logic [LW-1:0]  vic_reg, vic_next;     // entry whose links are written
    logic           pend_reg, pend_next;   // patch prev (not next) link
    logic [SW-1:0]  raddr_reg, raddr_next;
    logic [1:0]     rstat_reg, rstat_next;

    logic [6:0]  hdr_eff;
    logic [17:0] end_sum;
    logic [17:0] merge_sum;
    logic [SW-1:0] merge_sat;

    always_comb begin
        hdr_eff = hdr;
        if (hdr == '0) hdr_eff = 7'd1;
        if (hdr > 7'd64) hdr_eff = 7'd64;
    end

    // Wide enough that a large request on top of a full break cannot wrap.
    assign end_sum   = 18'(brk_reg) + 18'(hdr_eff) + 18'(size_reg);
    assign merge_sum = 18'(blk_reg.size) + 18'(oth_reg.size) + 18'(hdr_eff);
    assign merge_sat = (merge_sum > 18'hFFFF) ? 16'hFFFF : merge_sum[SW-1:0];

    assign busy        = (state_reg != ffha_pkg::S_IDLE);
    assign resp_valid  = (state_reg == ffha_pkg::S_RESP);
    assign resp_addr   = raddr_reg;
    assign resp_status = rstat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ffha_pkg::S_IDLE;
            head_reg  <= ffha_pkg::NIL;
            tail_reg  <= ffha_pkg::NIL;
            brk_reg   <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            brk_reg   <= brk_next;
        end
        cmd_reg   <= cmd_next;
        size_reg  <= size_next;
        addr_reg  <= addr_next;
        cur_reg   <= cur_next;
        steps_reg <= steps_next;
        blk_reg   <= blk_next;
        oth_reg   <= oth_next;
        vic_reg   <= vic_next;
        pend_reg  <= pend_next;
        raddr_reg <= raddr_next;
        rstat_reg <= rstat_next;
    end

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        brk_next      = brk_reg;
        cmd_next      = cmd_reg;
        size_next     = size_reg;
        addr_next     = addr_reg;
        cur_next      = cur_reg;
        steps_next    = steps_reg;
        blk_next      = blk_reg;
        oth_next      = oth_reg;
        vic_next      = vic_reg;
        pend_next     = pend_reg;
        raddr_next    = raddr_reg;
        rstat_next    = rstat_reg;
        mem_we        = 1'b0;
        mem_waddr     = cur_reg[IW-1:0];
        mem_wdata     = blk_reg;
        mem_raddr     = cur_reg[IW-1:0];
        slot_take     = 1'b0;
        slot_take_idx = slot.idx;
        slot_give     = 1'b0;
        slot_give_idx = vic_reg[IW-1:0];

        unique case (state_reg)
            ffha_pkg::S_IDLE: begin
                if (start) begin
                    cmd_next   = cmd;
                    size_next  = req_size;
                    addr_next  = addr;
                    cur_next   = head_reg;
                    steps_next = '0;
                    raddr_next = '0;
                    rstat_next = ffha_pkg::ST_DONE;
                    if (cmd == ffha_pkg::CMD_ALLOC && req_size == '0) begin
                        rstat_next = ffha_pkg::ST_FAIL;
                        state_next = ffha_pkg::S_RESP;
                    end else if (cmd == ffha_pkg::CMD_RELEASE && addr == '0) begin
                        state_next = ffha_pkg::S_RESP;
                    end else begin
                        state_next = ffha_pkg::S_READ;
                    end
                end
            end

            // Issue the read of the current entry or finish the walk.
            ffha_pkg::S_READ: begin
                mem_raddr = cur_reg[IW-1:0];
                if (cur_reg == ffha_pkg::NIL || steps_reg == CW'(ffha_pkg::MAX_BLOCKS)) begin
                    state_next = ffha_pkg::S_RESP;
                    if (cmd_reg == ffha_pkg::CMD_RELEASE) begin
                        rstat_next = ffha_pkg::ST_NOT_FOUND;
                    end else if (slot.full || end_sum > 18'(limit)) begin
                        rstat_next = ffha_pkg::ST_FAIL;
                    end else begin
                        // Append a new block at the break.
                        mem_we          = 1'b1;
                        mem_waddr       = slot.idx;
                        mem_wdata.offset = brk_reg[SW-1:0];
                        mem_wdata.size   = size_reg;
                        mem_wdata.is_free = 1'b0;
                        mem_wdata.next   = ffha_pkg::NIL;
                        mem_wdata.prev   = tail_reg;
                        slot_take       = 1'b1;
                        raddr_next      = brk_reg[SW-1:0] + SW'(hdr_eff);
                        brk_next        = end_sum[16:0];
                        tail_next       = {1'b0, slot.idx};
                        if (tail_reg == ffha_pkg::NIL) begin
                            head_next = {1'b0, slot.idx};
                        end else begin
                            // Patch old tail's next link via read-modify-write.
                            vic_next   = tail_reg;
                            oth_next.next = {1'b0, slot.idx};
                            mem_raddr  = tail_reg[IW-1:0];
                            state_next = ffha_pkg::S_REL_UNLINK2;
                            pend_next  = 1'b0;
                        end
                    end
                end else begin
                    state_next = ffha_pkg::S_CHECK;
                end
            end

            ffha_pkg::S_CHECK: begin
                blk_next   = mem_rdata;
                steps_next = steps_reg + 1'b1;
                cur_next   = mem_rdata.next;
                state_next = ffha_pkg::S_READ;
                if (cmd_reg == ffha_pkg::CMD_ALLOC) begin
                    if (mem_rdata.is_free && mem_rdata.size >= size_reg) begin
                        cur_next   = cur_reg;
                        raddr_next = mem_rdata.offset + SW'(hdr_eff);
                        mem_we     = 1'b1;
                        mem_waddr  = cur_reg[IW-1:0];
                        mem_wdata  = mem_rdata;
                        mem_wdata.is_free = 1'b0;
                        state_next = ffha_pkg::S_RESP;
                        if ((mem_rdata.size - size_reg) >= SW'(hdr_eff) && !slot.full) begin
                            mem_wdata.size = size_reg;
                            mem_wdata.next = {1'b0, slot.idx};
                            slot_take      = 1'b1;
                            blk_next.offset = mem_rdata.offset + SW'(hdr_eff) + size_reg;
                            blk_next.size   = mem_rdata.size - size_reg - SW'(hdr_eff);
                            blk_next.is_free = 1'b1;
                            blk_next.prev   = cur_reg;
                            blk_next.next   = mem_rdata.next;
                            vic_next        = {1'b0, slot.idx};
                            state_next      = ffha_pkg::S_SPLIT_NEXT;
                        end
                    end
                end else if (mem_rdata.offset + SW'(hdr_eff) == addr_reg) begin
                    cur_next   = cur_reg;
                    blk_next.is_free = 1'b1;
                    mem_raddr  = mem_rdata.next[IW-1:0];
                    state_next = ffha_pkg::S_REL_NEXT;
                end
            end

            // Write the split remainder and fix the follower's prev link.
            ffha_pkg::S_SPLIT_NEXT: begin
                mem_we    = 1'b1;
                mem_waddr = vic_reg[IW-1:0];
                mem_wdata = blk_reg;
                if (blk_reg.next == ffha_pkg::NIL) begin
                    tail_next  = vic_reg;
                    state_next = ffha_pkg::S_RESP;
                end else begin
                    mem_raddr  = blk_reg.next[IW-1:0];
                    cur_next   = blk_reg.next;
                    oth_next.prev = vic_reg;
                    pend_next  = 1'b1;
                    state_next = ffha_pkg::S_REL_UNLINK2;
                    vic_next   = blk_reg.next;
                end
            end

            // Next neighbour data arrives; absorb it if free.
            ffha_pkg::S_REL_NEXT: begin
                if (blk_reg.next != ffha_pkg::NIL && mem_rdata.is_free) begin
                    oth_next   = mem_rdata;
                    vic_next   = blk_reg.next;
                    state_next = ffha_pkg::S_REL_NEXT2;
                end else begin
                    mem_raddr  = blk_reg.prev[IW-1:0];
                    state_next = ffha_pkg::S_REL_PREV;
                end
            end

            ffha_pkg::S_REL_NEXT2: begin
                blk_next.size = merge_sat;
                blk_next.next = oth_reg.next;
                slot_give     = 1'b1;
                slot_give_idx = vic_reg[IW-1:0];
                if (oth_reg.next == ffha_pkg::NIL) begin
                    tail_next  = cur_reg;
                    mem_raddr  = blk_reg.prev[IW-1:0];
                    state_next = ffha_pkg::S_REL_PREV;
                end else begin
                    mem_raddr  = oth_reg.next[IW-1:0];
                    vic_next   = oth_reg.next;
                    oth_next.prev = cur_reg;
                    pend_next  = 1'b1;
                    state_next = ffha_pkg::S_REL_UNLINK;
                end
            end

            // Fix prev link of the entry after the absorbed one.
            ffha_pkg::S_REL_UNLINK: begin
                mem_we    = 1'b1;
                mem_waddr = vic_reg[IW-1:0];
                mem_wdata = mem_rdata;
                mem_wdata.prev = oth_reg.prev;
                mem_raddr  = blk_reg.prev[IW-1:0];
                state_next = ffha_pkg::S_REL_PREV;
            end

            ffha_pkg::S_REL_PREV: begin
                if (blk_reg.prev != ffha_pkg::NIL && mem_rdata.is_free) begin
                    oth_next   = mem_rdata;
                    state_next = ffha_pkg::S_REL_PREV2;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = cur_reg[IW-1:0];
                    mem_wdata  = blk_reg;
                    state_next = ffha_pkg::S_RESP;
                end
            end

            // Fold current into prev and drop current.
            ffha_pkg::S_REL_PREV2: begin
                mem_we         = 1'b1;
                mem_waddr      = blk_reg.prev[IW-1:0];
                mem_wdata      = oth_reg;
                mem_wdata.size = merge_sat;
                mem_wdata.next = blk_reg.next;
                slot_give      = 1'b1;
                slot_give_idx  = cur_reg[IW-1:0];
                if (blk_reg.next == ffha_pkg::NIL) begin
                    tail_next  = blk_reg.prev;
                    state_next = ffha_pkg::S_RESP;
                end else begin
                    mem_raddr  = blk_reg.next[IW-1:0];
                    vic_next   = blk_reg.next;
                    oth_next.prev = blk_reg.prev;
                    pend_next  = 1'b0;
                    state_next = ffha_pkg::S_REL_UNLINK2;
                end
            end

            // Generic link patch: vic's data has arrived; set one link.
            ffha_pkg::S_REL_UNLINK2: begin
                mem_we    = 1'b1;
                mem_waddr = vic_reg[IW-1:0];
                mem_wdata = mem_rdata;
                if (pend_reg) begin
                    mem_wdata.prev = oth_reg.prev;
                end else if (cmd_reg == ffha_pkg::CMD_ALLOC) begin
                    mem_wdata.next = oth_reg.next;
                end else begin
                    mem_wdata.prev = oth_reg.prev;
                end
                state_next = ffha_pkg::S_RESP;
            end

            ffha_pkg::S_RESP: begin
                if (resp_taken) begin
                    state_next = ffha_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = ffha_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* sv/first_fit_heap_allocator.sv */
// A zero-size allocate or a null release goes straight to the result; other
// requests walk the list, reading one entry at a time over the single-read-port
// block memory. One request in flight; the next is taken the cycle after its
// result enters the output register.
// Reset: synchronous active-low aresetn empties the list, zeros the break
// and restores header_bytes to 16 and heap_limit to 65536. No clearing pass.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with block split and free-neighbor merging.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ffha_pkg::LIM_W-1:0]         cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_cmd,
    input  logic [15:0]                        s_req_size,
    input  logic [15:0]                        s_addr,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [15:0]                        m_result_addr,
    output logic [1:0]                         m_status
);

    logic [ffha_pkg::HDR_W-1:0] hdr_reg;
    logic [ffha_pkg::LIM_W-1:0] lim_reg;
    logic [ffha_pkg::LIM_W-1:0] lim_eff;
    logic busy;
    logic mem_we;
    logic [ffha_pkg::IDX_W-1:0] mem_waddr, mem_raddr;
    ffha_pkg::blk_t mem_wdata, mem_rdata;
    ffha_pkg::slot_t slot;
    logic slot_take, slot_give;
    logic [ffha_pkg::IDX_W-1:0] slot_take_idx, slot_give_idx;
    logic        resp_valid, resp_taken;
    logic [15:0] resp_addr;
    logic [1:0]  resp_status;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_addr_reg, out_addr_next;
    logic [1:0]  out_status_reg, out_status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg <= 7'd16;
            lim_reg <= 17'd65536;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ffha_pkg::REG_HEADER_BYTES: hdr_reg <= cfg_data[ffha_pkg::HDR_W-1:0];
                ffha_pkg::REG_HEAP_LIMIT:   lim_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign lim_eff = (lim_reg > ffha_pkg::LIMIT_CAP) ? ffha_pkg::LIMIT_CAP : lim_reg;
    assign s_ready = !busy;

    // Output register: frees the walker while a result waits on the receiver.
    assign resp_taken = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (resp_valid && resp_taken) begin
            out_valid_next  = 1'b1;
            out_addr_next   = resp_addr;
            out_status_next = resp_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            out_addr_reg   <= '0;
            out_status_reg <= ffha_pkg::ST_DONE;
        end else begin
            out_valid_reg  <= out_valid_next;
            out_addr_reg   <= out_addr_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_addr = out_addr_reg;
    assign m_status      = out_status_reg;

    ffha_ram #(
        .WIDTH(ffha_pkg::BLK_W),
        .DEPTH(ffha_pkg::MAX_BLOCKS)
    ) u_tbl (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ffha_slots u_slots (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (slot_take),
        .take_idx (slot_take_idx),
        .give     (slot_give),
        .give_idx (slot_give_idx),
        .slot     (slot)
    );

    ffha_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (s_valid && s_ready),
        .cmd           (s_cmd),
        .req_size      (s_req_size),
        .addr          (s_addr),
        .hdr           (hdr_reg),
        .limit         (lim_eff),
        .resp_taken    (resp_taken),
        .busy          (busy),
        .resp_valid    (resp_valid),
        .resp_addr     (resp_addr),
        .resp_status   (resp_status),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .slot          (slot),
        .slot_take     (slot_take),
        .slot_take_idx (slot_take_idx),
        .slot_give     (slot_give),
        .slot_give_idx (slot_give_idx)
    );

endmodule

/* sv/ffha_checker.sv */
// ----------------------------------------------------------------------------
// ffha_props
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_defines.svh"

module ffha_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_result_addr,
    input logic [1:0]  m_status
);

    `FFHA_ASSERT(a_input_held, s_valid && !s_ready |=> s_valid, "request dropped")
    `FFHA_ASSERT(a_result_held, m_valid && !m_ready |=> m_valid && $stable(m_result_addr) && $stable(m_status), "result dropped")
    `FFHA_ASSERT(a_fail_zero_addr, m_valid && m_status != ffha_pkg::ST_DONE |-> m_result_addr == 16'd0, "failed result carries address")
    `FFHA_ASSERT(a_status_range, m_valid |-> (m_status == ffha_pkg::ST_DONE || m_status == ffha_pkg::ST_FAIL || m_status == ffha_pkg::ST_NOT_FOUND), "bad status code")
    `FFHA_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind first_fit_heap_allocator ffha_props u_ffha_props (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_addr (m_result_addr),
    .m_status      (m_status)
);
